// File: design/vlrf_pkg.sv
// Shared types, codes and default sizes for the variable-length record FIFO.
package vlrf_pkg;

    localparam int STORE_BYTES_DEF  = 1024;
    localparam int HEADER_BYTES_DEF = 1;
    localparam int MAX_RECORD_DEF   = 64;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    localparam int QDEPTH = 2;
    localparam int QAW    = 1;
    localparam int QCW    = 2;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_PEEK  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_EMPTY  = 2'd2
    } t_status;

    typedef struct packed {
        t_req              req;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  elem_len;
        logic              last_byte;
        logic [LEN_W-1:0]  max_len;
        logic              oversize;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              run_last;
        t_status           status;
        logic [LEN_W-1:0]  record_len;
        logic              is_empty;
        logic              is_full;
    } t_result;

endpackage

// File: design/vlrf_front.sv
// Front end: accepts transactions, classifies them and queues commands for the back end.
module vlrf_front #(
    parameter int MAX_RECORD = vlrf_pkg::MAX_RECORD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_req_type,
    input  logic [vlrf_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic [vlrf_pkg::LEN_W-1:0]    i_elem_len,
    input  logic                          i_last_byte,
    input  logic [vlrf_pkg::LEN_W-1:0]    i_max_len,
    output logic                          o_cmd_valid,
    output vlrf_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_ready
);
    import vlrf_pkg::*;

    t_cmd           r_q [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    t_cmd           c_cmd;
    logic           c_push;
    logic           c_pop;

    always_comb begin
        c_cmd.req       = t_req'(i_req_type);
        c_cmd.data_byte = i_data_byte;
        c_cmd.elem_len  = i_elem_len;
        c_cmd.last_byte = i_last_byte;
        c_cmd.max_len   = i_max_len;
        c_cmd.oversize  = (i_elem_len > LEN_W'(MAX_RECORD));
    end

    assign o_ready     = (r_cnt != QCW'(QDEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign c_push      = i_valid && o_ready;
    assign c_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (c_push) begin
                r_q[r_wp] <= c_cmd;
                r_wp      <= r_wp + QAW'(1);
            end
            if (c_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            case ({c_push, c_pop})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: design/vlrf_back.sv
// Back end: sequencer that executes queued commands against the byte ring store.
module vlrf_back #(
    parameter int STORE_BYTES  = vlrf_pkg::STORE_BYTES_DEF,
    parameter int HEADER_BYTES = vlrf_pkg::HEADER_BYTES_DEF,
    parameter int MAX_RECORD   = vlrf_pkg::MAX_RECORD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  vlrf_pkg::t_cmd    i_cmd,
    output logic              o_cmd_ready,
    output logic              o_res_valid,
    output vlrf_pkg::t_result o_res,
    input  logic              i_res_ready
);
    import vlrf_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam int FW = AW + 1;
    localparam int CW = AW + 8;
    localparam int HW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

    localparam logic [CW-1:0]    STORE_C = CW'(STORE_BYTES);
    localparam logic [FW-1:0]    STORE_F = FW'(STORE_BYTES);
    localparam logic [CW-1:0]    HDR_C   = CW'(HEADER_BYTES);
    localparam logic [LEN_W-1:0] MAX_C   = LEN_W'(MAX_RECORD);
    localparam logic [HW-1:0]    HLAST   = HW'(HEADER_BYTES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_HDR, S_DATA, S_PAD, S_RCHK,
        S_RHDR, S_RHACC, S_RLEN, S_RB, S_RBOUT, S_EMIT
    } t_state;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [CW-1:0] n);
        logic [CW-1:0] s;
        s = CW'(p) + n;
        if (s >= STORE_C) begin
            s = s - STORE_C;
        end
        return s[AW-1:0];
    endfunction

    t_state             r_state;
    t_cmd               r_cmd;
    logic [AW-1:0]      r_head;
    logic [AW-1:0]      r_tail;
    logic [AW-1:0]      r_wr;
    logic [AW-1:0]      r_rd;
    logic [FW-1:0]      r_free;
    logic               r_active;
    logic               r_rejecting;
    logic [LEN_W-1:0]   r_left;
    logic [HW-1:0]      r_hidx;
    logic [LEN_W-1:0]   r_hlen;
    logic               r_hbig;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_cnt;
    t_status            r_pst;
    t_result            r_res;
    logic               r_res_valid;

    logic [BYTE_W-1:0]  r_mem [STORE_BYTES];
    logic [BYTE_W-1:0]  r_rdata;

    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [BYTE_W-1:0]  mem_wd;
    logic               mem_re;
    logic [AW-1:0]      mem_ra;

    logic [CW-1:0]      c_need;
    logic               c_fit;
    logic               c_out_free;
    logic               c_res_load;
    logic [LEN_W-1:0]   c_len;
    logic [LEN_W-1:0]   c_cnt;
    logic [CW-1:0]      c_step;
    logic [CW-1:0]      c_freed;
    logic [FW-1:0]      c_free_pop;
    logic [LEN_W-1:0]   c_left_after;
    logic               c_empty;
    logic               c_full;

    assign c_need       = CW'(r_cmd.elem_len) + HDR_C;
    assign c_fit        = (c_need <= CW'(r_free));
    assign c_out_free   = !r_res_valid || i_res_ready;
    assign c_res_load   = ((r_state == S_RBOUT) || (r_state == S_EMIT)) && c_out_free;
    assign c_len        = r_hbig ? MAX_C : r_hlen;
    assign c_cnt        = (r_cmd.max_len < c_len) ? r_cmd.max_len : c_len;
    assign c_step       = CW'(c_len) + HDR_C;
    assign c_freed      = CW'(r_free) + c_step;
    assign c_free_pop   = (c_freed > STORE_C) ? STORE_F : c_freed[FW-1:0];
    assign c_left_after = (r_left != '0) ? (r_left - LEN_W'(1)) : r_left;
    assign c_empty      = (r_free == STORE_F);
    assign c_full       = (r_free == '0);

    assign o_cmd_ready  = (r_state == S_IDLE);
    assign o_res_valid  = r_res_valid;
    assign o_res        = r_res;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wr;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = r_rd;
        unique case (r_state)
            S_HDR: begin
                mem_we = 1'b1;
                mem_wa = r_rd;
                mem_wd = (r_hidx == '0) ? {1'b0, r_cmd.elem_len} : '0;
            end
            S_DATA: begin
                mem_we = (r_left != '0);
                mem_wd = r_cmd.data_byte;
            end
            S_PAD: begin
                mem_we = 1'b1;
            end
            S_RHDR, S_RB: begin
                mem_re = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_wr        <= '0;
            r_free      <= STORE_F;
            r_active    <= 1'b0;
            r_rejecting <= 1'b0;
            r_left      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= c_res_load || (r_res_valid && !i_res_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_len <= '0;
                    r_pst <= ST_OK;
                    unique case (r_cmd.req) inside
                        REQ_CLEAR: begin
                            r_head      <= '0;
                            r_tail      <= '0;
                            r_wr        <= '0;
                            r_free      <= STORE_F;
                            r_active    <= 1'b0;
                            r_rejecting <= 1'b0;
                            r_left      <= '0;
                            r_state     <= S_EMIT;
                        end
                        REQ_PUSH: begin
                            if (r_rejecting) begin
                                r_pst <= ST_REJECT;
                                if (r_cmd.last_byte) begin
                                    r_rejecting <= 1'b0;
                                end
                                r_state <= S_EMIT;
                            end else if (!r_active) begin
                                if (r_cmd.oversize || !c_fit) begin
                                    r_pst       <= ST_REJECT;
                                    r_rejecting <= !r_cmd.last_byte;
                                    r_state     <= S_EMIT;
                                end else begin
                                    r_rd     <= r_tail;
                                    r_hidx   <= '0;
                                    r_wr     <= adv(r_tail, HDR_C);
                                    r_tail   <= adv(r_tail, c_need);
                                    r_free   <= r_free - c_need[FW-1:0];
                                    r_left   <= r_cmd.elem_len;
                                    r_active <= 1'b1;
                                    r_state  <= S_HDR;
                                end
                            end else begin
                                r_state <= S_DATA;
                            end
                        end
                        REQ_POP, REQ_PEEK: begin
                            r_rejecting <= 1'b0;
                            if (r_left != '0) begin
                                r_state <= S_PAD;
                            end else begin
                                r_active <= 1'b0;
                                r_state  <= S_RCHK;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_HDR: begin
                    r_rd   <= adv(r_rd, CW'(1));
                    r_hidx <= r_hidx + HW'(1);
                    if (r_hidx == HLAST) begin
                        r_state <= S_DATA;
                    end
                end
                S_DATA: begin
                    if (r_left != '0) begin
                        r_wr   <= adv(r_wr, CW'(1));
                        r_left <= c_left_after;
                    end
                    if (r_cmd.last_byte && (c_left_after != '0)) begin
                        r_state <= S_PAD;
                    end else begin
                        if (r_cmd.last_byte) begin
                            r_active    <= 1'b0;
                            r_rejecting <= 1'b0;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_PAD: begin
                    r_wr   <= adv(r_wr, CW'(1));
                    r_left <= r_left - LEN_W'(1);
                    if (r_left == LEN_W'(1)) begin
                        r_active    <= 1'b0;
                        r_rejecting <= 1'b0;
                        r_state     <= (r_cmd.req == REQ_PUSH) ? S_EMIT : S_RCHK;
                    end
                end
                S_RCHK: begin
                    if (r_free >= STORE_F) begin
                        r_pst   <= ST_EMPTY;
                        r_state <= S_EMIT;
                    end else begin
                        r_rd    <= r_head;
                        r_hidx  <= '0;
                        r_hlen  <= '0;
                        r_hbig  <= 1'b0;
                        r_state <= S_RHDR;
                    end
                end
                S_RHDR: begin
                    r_rd    <= adv(r_rd, CW'(1));
                    r_state <= S_RHACC;
                end
                S_RHACC: begin
                    if (r_hidx == '0) begin
                        r_hlen <= r_rdata[LEN_W-1:0];
                        r_hbig <= (r_rdata > {1'b0, MAX_C});
                    end else if (r_rdata != '0) begin
                        r_hbig <= 1'b1;
                    end
                    if (r_hidx == HLAST) begin
                        r_state <= S_RLEN;
                    end else begin
                        r_hidx  <= r_hidx + HW'(1);
                        r_state <= S_RHDR;
                    end
                end
                S_RLEN: begin
                    r_len <= c_len;
                    if (r_cmd.req == REQ_POP) begin
                        r_free <= c_free_pop;
                        r_head <= adv(r_head, c_step);
                    end
                    if (c_cnt == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_cnt   <= c_cnt;
                        r_state <= S_RB;
                    end
                end
                S_RB: begin
                    r_rd    <= adv(r_rd, CW'(1));
                    r_state <= S_RBOUT;
                end
                S_RBOUT: begin
                    if (c_out_free) begin
                        r_res <= '{out_byte: r_rdata, byte_valid: 1'b1,
                                   run_last: (r_cnt == LEN_W'(1)), status: ST_OK,
                                   record_len: r_len, is_empty: c_empty, is_full: c_full};
                        r_cnt       <= r_cnt - LEN_W'(1);
                        r_state     <= (r_cnt == LEN_W'(1)) ? S_IDLE : S_RB;
                    end
                end
                S_EMIT: begin
                    if (c_out_free) begin
                        r_res <= '{out_byte: '0, byte_valid: 1'b0, run_last: 1'b1,
                                   status: r_pst, record_len: r_len,
                                   is_empty: c_empty, is_full: c_full};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/variable_length_record_fifo.sv
// Top level of the variable-length record FIFO over a byte ring store.
//
//   channel   handshake           payload
//   request   i_valid / o_ready   i_req_type i_data_byte i_elem_len i_last_byte i_max_len
//   result    o_valid / i_ready   o_out_byte o_byte_valid o_run_last o_status o_record_len
//                                 o_is_empty o_is_full
//
// A push transaction passes the sequencer through S_EXEC, then S_HDR once per header byte
// on the first byte of a record, S_DATA and S_EMIT; a rejected push or a clear goes from
// S_EXEC straight to S_EMIT, and a short record is padded with zero bytes in S_PAD.
// Pop and peek read each header byte through S_RHDR and S_RHACC, then each byte through
// S_RB and S_RBOUT: the single-port store with registered read data sets this sequence.
// Reset synchronously clears pointers and counters; store contents stay unknown until written.
// A two-entry command queue keeps taking transactions, until it is full, while the output register stalls.
module variable_length_record_fifo #(
    parameter int STORE_BYTES  = vlrf_pkg::STORE_BYTES_DEF,
    parameter int HEADER_BYTES = vlrf_pkg::HEADER_BYTES_DEF,
    parameter int MAX_RECORD   = vlrf_pkg::MAX_RECORD_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_req_type,
    input  logic [vlrf_pkg::BYTE_W-1:0] i_data_byte,
    input  logic [vlrf_pkg::LEN_W-1:0]  i_elem_len,
    input  logic                        i_last_byte,
    input  logic [vlrf_pkg::LEN_W-1:0]  i_max_len,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [vlrf_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_byte_valid,
    output logic                        o_run_last,
    output logic [1:0]                  o_status,
    output logic [vlrf_pkg::LEN_W-1:0]  o_record_len,
    output logic                        o_is_empty,
    output logic                        o_is_full
);
    import vlrf_pkg::*;

    t_cmd    cmd;
    logic    cmd_valid;
    logic    cmd_ready;
    t_result res;

    vlrf_front #(
        .MAX_RECORD (MAX_RECORD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .i_elem_len  (i_elem_len),
        .i_last_byte (i_last_byte),
        .i_max_len   (i_max_len),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    vlrf_back #(
        .STORE_BYTES  (STORE_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_RECORD   (MAX_RECORD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_res_valid (o_valid),
        .o_res       (res),
        .i_res_ready (i_ready)
    );

    assign o_out_byte   = res.out_byte;
    assign o_byte_valid = res.byte_valid;
    assign o_run_last   = res.run_last;
    assign o_status     = res.status;
    assign o_record_len = res.record_len;
    assign o_is_empty   = res.is_empty;
    assign o_is_full    = res.is_full;

endmodule

// File: design/vlrf_checker.sv
// Port-level assertions for the variable-length record FIFO, bound to the top level.
module vlrf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [vlrf_pkg::BYTE_W-1:0] o_out_byte,
    input logic                        o_byte_valid,
    input logic                        o_run_last,
    input logic [1:0]                  o_status,
    input logic [vlrf_pkg::LEN_W-1:0]  o_record_len,
    input logic                        o_is_empty,
    input logic                        o_is_full
);
    import vlrf_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable({o_out_byte, o_byte_valid, o_run_last,
                                                     o_status, o_record_len, o_is_empty,
                                                     o_is_full}))
        else $error("result changed while stalled");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_empty && o_is_full))
        else $error("empty and full flagged together");

    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_valid |-> o_status == ST_OK && o_record_len != '0)
        else $error("record byte without ok status or length");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_run_last && !o_byte_valid && o_record_len == '0)
        else $error("error result not a single empty transaction");

endmodule

bind variable_length_record_fifo vlrf_checker u_vlrf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_out_byte   (o_out_byte),
    .o_byte_valid (o_byte_valid),
    .o_run_last   (o_run_last),
    .o_status     (o_status),
    .o_record_len (o_record_len),
    .o_is_empty   (o_is_empty),
    .o_is_full    (o_is_full)
);

// File: tb/sv/vlrf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the variable-length record FIFO: mirrors the ring store, checks every result.
module vlrf_scoreboard (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_ready,
    input  logic [1:0]                  i_req_type,
    input  logic [vlrf_pkg::BYTE_W-1:0] i_data_byte,
    input  logic [vlrf_pkg::LEN_W-1:0]  i_elem_len,
    input  logic                        i_last_byte,
    input  logic [vlrf_pkg::LEN_W-1:0]  i_max_len,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic [vlrf_pkg::BYTE_W-1:0] o_out_byte,
    input  logic                        o_byte_valid,
    input  logic                        o_run_last,
    input  logic [1:0]                  o_status,
    input  logic [vlrf_pkg::LEN_W-1:0]  o_record_len,
    input  logic                        o_is_empty,
    input  logic                        o_is_full,
    output int                          o_fail_count,
    output int                          o_pending
);
    import vlrf_pkg::*;

    localparam int RING    = STORE_BYTES_DEF;
    localparam int HDR     = HEADER_BYTES_DEF;
    localparam int REC_MAX = MAX_RECORD_DEF;

    logic [BYTE_W-1:0] ring_mem [RING];
    int                head_idx;
    int                tail_idx;
    int                write_idx;
    int                free_count;
    int                bytes_owed;
    bit                record_open;
    bit                record_dropping;
    t_result           expected_results [$];
    int                mismatches = 0;

    task automatic queue_result(input logic [BYTE_W-1:0] b, input logic v, input logic last,
                                input t_status st, input int rlen);
        t_result r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.run_last   = last;
        r.status     = st;
        r.record_len = rlen[LEN_W-1:0];
        r.is_empty   = (free_count == RING);
        r.is_full    = (free_count == 0);
        expected_results.push_back(r);
    endtask

    task automatic close_record();
        while (bytes_owed > 0) begin
            ring_mem[write_idx] = '0;
            write_idx = (write_idx + 1) % RING;
            bytes_owed--;
        end
        record_open     = 1'b0;
        record_dropping = 1'b0;
    endtask

    task automatic predict_push(input logic [BYTE_W-1:0] data, input int elen, input logic last);
        int need;
        need = elen + HDR;
        if (record_dropping) begin
            if (last)
                record_dropping = 1'b0;
            queue_result('0, 1'b0, 1'b1, ST_REJECT, 0);
            return;
        end
        if (!record_open) begin
            if (elen > REC_MAX || need > free_count) begin
                record_dropping = !last;
                queue_result('0, 1'b0, 1'b1, ST_REJECT, 0);
                return;
            end
            for (int i = 0; i < HDR; i++)
                ring_mem[(tail_idx + i) % RING] = 8'((longint'(elen) >> (8 * i)) & 255);
            write_idx   = (tail_idx + HDR) % RING;
            tail_idx    = (tail_idx + need) % RING;
            free_count  = free_count - need;
            bytes_owed  = elen;
            record_open = 1'b1;
        end
        if (bytes_owed > 0) begin
            ring_mem[write_idx] = data;
            write_idx = (write_idx + 1) % RING;
            bytes_owed--;
        end
        if (last)
            close_record();
        queue_result('0, 1'b0, 1'b1, ST_OK, 0);
    endtask

    task automatic predict_read(input bit remove, input int limit);
        longint hdr;
        int     rlen;
        int     count;
        int     first;
        close_record();
        if (free_count >= RING) begin
            queue_result('0, 1'b0, 1'b1, ST_EMPTY, 0);
            return;
        end
        hdr = 0;
        for (int i = 0; i < HDR; i++)
            hdr = hdr | (longint'(ring_mem[(head_idx + i) % RING]) << (8 * i));
        rlen  = (hdr > REC_MAX) ? REC_MAX : int'(hdr);
        count = (limit < rlen) ? limit : rlen;
        first = (head_idx + HDR) % RING;
        if (remove) begin
            free_count = (free_count + rlen + HDR > RING) ? RING : free_count + rlen + HDR;
            head_idx   = (head_idx + rlen + HDR) % RING;
        end
        if (count == 0)
            queue_result('0, 1'b0, 1'b1, ST_OK, rlen);
        else
            for (int k = 0; k < count; k++)
                queue_result(ring_mem[(first + k) % RING], 1'b1, k == count - 1, ST_OK, rlen);
    endtask

    task automatic clear_ring();
        head_idx        = 0;
        tail_idx        = 0;
        write_idx       = 0;
        free_count      = RING;
        bytes_owed      = 0;
        record_open     = 1'b0;
        record_dropping = 1'b0;
    endtask

    task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            clear_ring();
            expected_results.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected: out_byte %0d status %0d",
                           o_out_byte, o_status);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("out_byte", want.out_byte, o_out_byte);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(o_byte_valid));
                    check_field("run_last", 8'(want.run_last), 8'(o_run_last));
                    check_field("status", 8'(want.status), 8'(o_status));
                    check_field("record_len", 8'(want.record_len), 8'(o_record_len));
                    check_field("is_empty", 8'(want.is_empty), 8'(o_is_empty));
                    check_field("is_full", 8'(want.is_full), 8'(o_is_full));
                end
            end
            if (i_valid && o_ready) begin
                case (t_req'(i_req_type))
                    REQ_PUSH: predict_push(i_data_byte, int'(i_elem_len), i_last_byte);
                    REQ_POP:  predict_read(1'b1, int'(i_max_len));
                    REQ_PEEK: predict_read(1'b0, int'(i_max_len));
                    default:  begin
                        clear_ring();
                        queue_result('0, 1'b0, 1'b1, ST_OK, 0);
                    end
                endcase
            end
        end
        o_pending    = expected_results.size();
        o_fail_count = mismatches;
    end

endmodule

// File: tb/sv/tb_variable_length_record_fifo.sv
`timescale 1ns / 1ps
// Top-level testbench for the variable-length record FIFO: stimulus, watchdog and verdict.
module tb_variable_length_record_fifo;
    import vlrf_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_req_type;
    logic [BYTE_W-1:0] i_data_byte;
    logic [LEN_W-1:0]  i_elem_len;
    logic              i_last_byte;
    logic [LEN_W-1:0]  i_max_len;
    logic              o_valid;
    logic              i_ready;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_byte_valid;
    logic              o_run_last;
    logic [1:0]        o_status;
    logic [LEN_W-1:0]  o_record_len;
    logic              o_is_empty;
    logic              o_is_full;

    int fail_count;
    int pending;
    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int ready_hold_cycles = 0;
    int sent_items        = 0;
    int quiet_cycles      = 0;

    variable_length_record_fifo dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_data_byte  (i_data_byte),
        .i_elem_len   (i_elem_len),
        .i_last_byte  (i_last_byte),
        .i_max_len    (i_max_len),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_run_last   (o_run_last),
        .o_status     (o_status),
        .o_record_len (o_record_len),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full)
    );

    vlrf_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_data_byte  (i_data_byte),
        .i_elem_len   (i_elem_len),
        .i_last_byte  (i_last_byte),
        .i_max_len    (i_max_len),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_run_last   (o_run_last),
        .o_status     (o_status),
        .o_record_len (o_record_len),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (ready_hold_cycles > 0) begin
                i_ready <= 1'b0;
                ready_hold_cycles = ready_hold_cycles - 1;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("variable_length_record_fifo test failed");
                $finish;
            end
        end
    end

    // Call at a falling edge; returns at the falling edge after the transaction.
    task automatic send_request(input t_req req, input logic [BYTE_W-1:0] data,
                                input logic [LEN_W-1:0] elen, input logic last,
                                input logic [LEN_W-1:0] maxl);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(4, 1);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_data_byte <= data;
        i_elem_len  <= elen;
        i_last_byte <= last;
        i_max_len   <= maxl;
        do @(posedge i_clk); while (!o_ready);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic push_record(input int elen, input int items, input bit close);
        for (int k = 0; k < items; k++)
            send_request(REQ_PUSH, 8'($urandom_range(255)), 7'(elen),
                         close && (k == items - 1), 7'($urandom_range(127)));
    endtask

    task automatic read_record(input t_req req);
        int maxl;
        maxl = ($urandom_range(9) < 8) ? $urandom_range(64) : $urandom_range(127);
        send_request(req, 8'($urandom_range(255)), 7'($urandom_range(127)),
                     1'($urandom_range(1)), 7'(maxl));
    endtask

    function automatic int random_length();
        int pick;
        pick = $urandom_range(9);
        if (pick < 7)
            return $urandom_range(12);
        if (pick < 9)
            return $urandom_range(64, 13);
        return $urandom_range(127, 65);
    endfunction

    task automatic run_random(input int quota);
        int goal;
        int pick;
        int elen;
        int items;
        goal = sent_items + quota;
        while (sent_items < goal) begin
            pick = $urandom_range(99);
            if (pick < 48) begin
                elen  = random_length();
                items = (elen == 0) ? 1 : (elen > MAX_RECORD_DEF) ? $urandom_range(4, 1) : elen;
                case ($urandom_range(9))
                    0:       items = $urandom_range(items, 1);
                    1:       items = items + $urandom_range(3, 1);
                    default: ;
                endcase
                push_record(elen, items, 1'b1);
            end else if (pick < 56) begin
                push_record($urandom_range(64, 32), 1, 1'b1);
            end else if (pick < 60) begin
                push_record(random_length(), $urandom_range(3, 1), 1'b0);
            end else if (pick < 64) begin
                send_request(REQ_PUSH, 8'($urandom_range(255)), 7'($urandom_range(127)),
                             1'($urandom_range(1)), 7'($urandom_range(127)));
            end else if (pick < 80) begin
                read_record(REQ_POP);
            end else if (pick < 94) begin
                read_record(REQ_PEEK);
            end else begin
                read_record(REQ_CLEAR);
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req_type  = REQ_PUSH;
        i_data_byte = '0;
        i_elem_len  = '0;
        i_last_byte = 1'b0;
        i_max_len   = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(REQ_POP,   8'h00, 7'd0,   1'b0, 7'd64);
        send_request(REQ_PEEK,  8'h00, 7'd0,   1'b0, 7'd127);
        send_request(REQ_PUSH,  8'h00, 7'd3,   1'b0, 7'd0);
        send_request(REQ_PUSH,  8'hFF, 7'd3,   1'b0, 7'd0);
        send_request(REQ_PUSH,  8'hA5, 7'd3,   1'b1, 7'd0);
        send_request(REQ_PEEK,  8'h00, 7'd0,   1'b0, 7'd127);
        send_request(REQ_PEEK,  8'h00, 7'd0,   1'b0, 7'd0);
        send_request(REQ_POP,   8'h00, 7'd0,   1'b0, 7'd2);
        send_request(REQ_PUSH,  8'h3C, 7'd0,   1'b1, 7'd0);
        send_request(REQ_POP,   8'h00, 7'd0,   1'b0, 7'd64);
        send_request(REQ_PUSH,  8'h01, 7'd65,  1'b0, 7'd0);
        send_request(REQ_PUSH,  8'h5A, 7'd65,  1'b1, 7'd0);
        send_request(REQ_PUSH,  8'h02, 7'd127, 1'b1, 7'd0);
        send_request(REQ_PUSH,  8'h11, 7'd5,   1'b0, 7'd0);
        send_request(REQ_PUSH,  8'h22, 7'd5,   1'b1, 7'd0);
        send_request(REQ_PUSH,  8'h33, 7'd2,   1'b0, 7'd0);
        send_request(REQ_PUSH,  8'h44, 7'd2,   1'b0, 7'd0);
        send_request(REQ_PUSH,  8'h55, 7'd2,   1'b0, 7'd0);
        send_request(REQ_PUSH,  8'h66, 7'd2,   1'b1, 7'd0);
        send_request(REQ_PUSH,  8'h77, 7'd4,   1'b0, 7'd0);
        send_request(REQ_PEEK,  8'h00, 7'd0,   1'b0, 7'd127);
        send_request(REQ_POP,   8'h00, 7'd0,   1'b0, 7'd127);
        send_request(REQ_POP,   8'h00, 7'd0,   1'b0, 7'd127);
        send_request(REQ_POP,   8'h00, 7'd0,   1'b0, 7'd127);
        send_request(REQ_PUSH,  8'h88, 7'd10,  1'b0, 7'd0);
        send_request(REQ_CLEAR, 8'h00, 7'd0,   1'b0, 7'd0);
        send_request(REQ_POP,   8'h00, 7'd0,   1'b0, 7'd64);
        drain_results();

        // Hold the result side at the start; the pushes then fill the ring to the last byte.
        ready_hold_cycles = HOLD_CYCLES;
        repeat (15) push_record(MAX_RECORD_DEF, 1, 1'b1);
        push_record(48, 1, 1'b1);
        send_request(REQ_PUSH, 8'h99, 7'd0, 1'b1, 7'd0);
        send_request(REQ_PEEK, 8'h00, 7'd0, 1'b0, 7'd127);
        send_request(REQ_POP,  8'h00, 7'd0, 1'b0, 7'd127);
        push_record(63, 1, 1'b1);
        push_record(0, 1, 1'b1);
        drain_results();

        send_idle_pct = 9;
        recv_idle_pct = 65;
        run_random(135);
        drain_results();
        send_idle_pct = 65;
        recv_idle_pct = 9;
        run_random(135);
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(125);
        drain_results();
        repeat (50) @(negedge i_clk);

        if (fail_count == 0)
            $display("variable_length_record_fifo test passed");
        else
            $display("variable_length_record_fifo test failed");
        $finish;
    end

endmodule
